@@ rtl/cfv_pkg.sv @@
// cfv_pkg: types, codes and the crc step for the control frame validator
// depends on nothing; imported by control_frame_validator
`default_nettype none

package cfv_pkg;

    // frame layout
    localparam int FRAME_BYTES = 16;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int INDEX_W     = $clog2(FRAME_BYTES);
    localparam int CRC_SPAN    = 14;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // header bytes
    localparam logic [7:0] MAGIC_M   = 8'h4D;
    localparam logic [7:0] MAGIC_0   = 8'h30;
    localparam logic [7:0] MAGIC_K   = 8'h4B;
    localparam logic [7:0] MAGIC_P   = 8'h50;
    localparam logic [7:0] MAGIC_C   = 8'h43;
    localparam logic [7:0] VERSION   = 8'd1;

    // key and panel field codes
    localparam logic [7:0] KEY_DOWN     = 8'd1;
    localparam logic [7:0] KEY_UP       = 8'd2;
    localparam logic [7:0] TGT_SWITCH   = 8'd1;
    localparam logic [7:0] TGT_BUZZER   = 8'd2;
    localparam logic [7:0] TGT_MODE     = 8'd3;
    localparam logic [7:0] MODE_NORMAL  = 8'd0;
    localparam logic [7:0] MODE_ALT     = 8'd11;

    // configuration register indexes
    localparam int          CFG_ADDR_W  = 4;
    localparam logic [1:0]  REG_SERVER_IP   = 2'd0;
    localparam logic [1:0]  REG_SERVER_PORT = 2'd1;
    localparam logic [1:0]  REG_MAX_KEY     = 2'd2;
    localparam logic [7:0]  MAX_KEY_RESET   = 8'd10;

    // verdict codes
    typedef enum logic [3:0] {
        VERDICT_KEY        = 4'd0,
        VERDICT_SWITCH     = 4'd1,
        VERDICT_BUZZER     = 4'd2,
        VERDICT_MODE       = 4'd3,
        VERDICT_LENGTH     = 4'd4,
        VERDICT_HEADER     = 4'd5,
        VERDICT_CRC        = 4'd6,
        VERDICT_KEY_FIELDS = 4'd7,
        VERDICT_PANEL      = 4'd8
    } verdict_t;

    // input beat
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] source_ip;
        logic [15:0] source_port;
    } byte_beat_t;

    // result beat
    typedef struct packed {
        logic [3:0]  verdict;
        logic [7:0]  target;
        logic [7:0]  action;
        logic [7:0]  value;
        logic [31:0] cmd_word;
        logic [15:0] frame_crc;
        logic [15:0] computed_crc;
    } result_beat_t;

    // one byte through the crc, msb first, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {data_in, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/control_frame_validator.sv @@
// control_frame_validator: checks 16-byte control datagrams byte by byte
// depends on cfv_pkg for beat types, verdict codes and the crc step
//
// usage:
//   byte channel (byte_valid/byte_stall/byte_data) takes one datagram byte per
//   beat; last_byte marks the final byte, source_ip/source_port are sampled
//   with it. bytes past the sixteenth are dropped, the frame still counts.
//   result channel (result_valid/result_stall/result_data) gives one verdict
//   beat for each last byte, none for other bytes.
//   the last byte is stored with pending_reg set, then judged into the output
//   register once that register is free.
//   throughput: one byte per clock while byte_stall is low; the crc step is one
//   byte wide and done in the same cycle the byte is taken.
//   when the receiver stalls, the result holds in the output register; a
//   second finished frame waits in the judge stage and byte_stall rises only
//   while both are occupied.
//   reset clears the byte count, pending and valid flags, loads the crc with
//   CRC_INIT and the register defaults (server_ip 0, server_port 0, max_key 10).
//   configuration: apb-style port, registers at byte addresses 0, 4 and 8, to be
//   written only while no frame is in flight; the block does not enforce it.
`default_nettype none

module control_frame_validator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // byte channel
    input  wire logic                             byte_valid,
    output      logic                             byte_stall,
    input  wire cfv_pkg::byte_beat_t              byte_data,
    // result channel
    output      logic                             result_valid,
    input  wire logic                             result_stall,
    output      cfv_pkg::result_beat_t            result_data,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cfv_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output      logic [31:0]                      prdata,
    output      logic                             pready
);
    import cfv_pkg::*;

    // configuration registers
    logic [31:0] server_ip_reg;
    logic [15:0] server_port_reg;
    logic [7:0]  max_key_reg;

    // frame collection state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        crc_reg, crc_next, crc_base;
    logic [7:0]         store_reg [FRAME_BYTES];
    logic               pending_reg;
    logic               frame_ok_reg, frame_ok_next;

    // output register
    logic               out_valid_reg;
    result_beat_t       out_beat_reg, out_beat_next;

    logic               byte_accept;
    logic               out_free;
    logic               cfg_write;
    logic [1:0]         cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_ip_reg   <= '0;
            server_port_reg <= '0;
            max_key_reg     <= MAX_KEY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SERVER_IP:   server_ip_reg   <= pwdata;
                REG_SERVER_PORT: server_port_reg <= pwdata[15:0];
                REG_MAX_KEY:     max_key_reg     <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (cfg_index)
            REG_SERVER_IP:   prdata = server_ip_reg;
            REG_SERVER_PORT: prdata = {16'h0000, server_port_reg};
            REG_MAX_KEY:     prdata = {24'h000000, max_key_reg};
            default:         prdata = '0;
        endcase
    end

    // handshake: hold off bytes only while a judged frame cannot move on
    assign out_free    = !out_valid_reg || !result_stall;
    assign byte_stall  = pending_reg && !out_free;
    assign byte_accept = byte_valid && !byte_stall;

    // byte count, crc and length/source check for the incoming beat
    always_comb
    begin
        crc_base        = (byte_count_reg == '0) ? CRC_INIT : crc_reg;
        crc_next        = crc_base;
        byte_count_next = byte_count_reg;
        if (byte_count_reg < COUNT_W'(FRAME_BYTES))
        begin
            if (byte_count_reg < COUNT_W'(CRC_SPAN))
                crc_next = crc_feed(crc_base, byte_data.data_byte);
            byte_count_next = byte_count_reg + COUNT_W'(1);
        end
        frame_ok_next = (byte_count_next == COUNT_W'(FRAME_BYTES))
                     && (byte_data.source_ip == server_ip_reg)
                     && (byte_data.source_port == server_port_reg);
    end

    // collection control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (byte_accept)
            begin
                crc_reg        <= crc_next;
                byte_count_reg <= byte_data.last_byte ? '0 : byte_count_next;
            end
            if (byte_accept && byte_data.last_byte)
                pending_reg <= 1'b1;
            else if (out_free)
                pending_reg <= 1'b0;
        end
    end

    // frame bytes and length/source flag
    always_ff @(posedge clk)
    begin
        if (byte_accept && (byte_count_reg < COUNT_W'(FRAME_BYTES)))
            store_reg[byte_count_reg[INDEX_W-1:0]] <= byte_data.data_byte;
        if (byte_accept && byte_data.last_byte)
            frame_ok_reg <= frame_ok_next;
    end

    // judge the stored frame
    always_comb
    begin
        logic        head;
        logic        is_key;
        logic        panel_frame;
        logic [15:0] rx_crc;
        verdict_t    verdict;

        head        = (store_reg[0] == MAGIC_M) && (store_reg[1] == MAGIC_0)
                   && (store_reg[3] == MAGIC_C);
        is_key      = head && (store_reg[2] == MAGIC_K);
        panel_frame = head && (store_reg[2] == MAGIC_P);
        rx_crc      = {store_reg[14], store_reg[15]};

        priority if (!is_key && !panel_frame || store_reg[4] != VERSION
                     || store_reg[12] != 8'h00 || store_reg[13] != 8'h00)
            verdict = VERDICT_HEADER;
        else if (rx_crc != crc_reg)
            verdict = VERDICT_CRC;
        else if (is_key)
        begin
            if (store_reg[5] == 8'h00 || store_reg[5] > max_key_reg
                || (store_reg[6] != KEY_DOWN && store_reg[6] != KEY_UP)
                || store_reg[7] != 8'h00)
                verdict = VERDICT_KEY_FIELDS;
            else
                verdict = VERDICT_KEY;
        end
        else if (store_reg[5] == TGT_SWITCH && store_reg[7] <= 8'd1)
            verdict = VERDICT_SWITCH;
        else if (store_reg[5] == TGT_BUZZER && store_reg[6] == 8'h00
                 && store_reg[7] <= 8'd1)
            verdict = VERDICT_BUZZER;
        else if (store_reg[5] == TGT_MODE
                 && (store_reg[6] == MODE_NORMAL || store_reg[6] == MODE_ALT)
                 && store_reg[7] == 8'h00)
            verdict = VERDICT_MODE;
        else
            verdict = VERDICT_PANEL;

        out_beat_next = '0;
        if (!frame_ok_reg)
            out_beat_next.verdict = VERDICT_LENGTH;
        else
        begin
            out_beat_next.verdict      = verdict;
            out_beat_next.target       = store_reg[5];
            out_beat_next.action       = store_reg[6];
            out_beat_next.value        = store_reg[7];
            out_beat_next.cmd_word     = {store_reg[8], store_reg[9],
                                          store_reg[10], store_reg[11]};
            out_beat_next.frame_crc    = rx_crc;
            out_beat_next.computed_crc = crc_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= pending_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pending_reg)
            out_beat_reg <= out_beat_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_beat_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (pending_reg && result_valid && result_stall))
        else $error("byte_stall raised with a free result path");

    a_last_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && byte_data.last_byte) |=> (pending_reg && byte_count_reg == '0))
        else $error("last byte did not close the frame");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= COUNT_W'(FRAME_BYTES))
        else $error("byte count past frame length");

    a_length_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.verdict == VERDICT_LENGTH)
            |-> (result_data.cmd_word == '0 && result_data.computed_crc == '0))
        else $error("length reject carries frame fields");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.verdict <= VERDICT_PANEL))
        else $error("verdict code out of range");

endmodule

`default_nettype wire

@@ verif/tb_control_frame_validator.sv @@
`timescale 1ns / 100ps
// tb_control_frame_validator: self-checking bench for the control frame validator
// depends on cfv_pkg (beat types, verdict codes, magic bytes) and the rtl top level

module tb_control_frame_validator;

    import cfv_pkg::*;

    localparam int CYCLE_LIMIT = 120000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_GAP   = 6;
    localparam int PRINT_CAP   = 30;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         byte_valid = 1'b0;
    logic         byte_stall;
    byte_beat_t   byte_data = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result_data;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    control_frame_validator dut (
        .clk,
        .rst_n,
        .byte_valid,
        .byte_stall,
        .byte_data,
        .result_valid,
        .result_stall,
        .result_data,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // bench copy of the registers
    logic [31:0] cfg_server_ip = '0;
    logic [15:0] cfg_server_port = '0;
    logic [7:0]  cfg_max_key = MAX_KEY_RESET;

    // frame tracker state
    int          frame_len;
    logic [15:0] crc_run;
    logic [7:0]  frame_bytes [FRAME_BYTES];

    byte_beat_t   byte_backlog [$];
    result_beat_t expected_verdicts [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served;
    int hold_left;
    int error_count = 0;
    int bytes_queued = 0;
    int bytes_taken;
    int cycle_count = 0;
    int verdict_tally [9];

    logic [7:0] draft [FRAME_BYTES];

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // crc-16/ccitt-false, one data bit per shift
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ d[i];
            r = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    // classify a complete, length- and source-checked frame
    function automatic verdict_t judge_frame();
        logic        head;
        logic        is_key;
        logic        panel_frame;
        logic [15:0] rx_crc;
        head = frame_bytes[0] == MAGIC_M && frame_bytes[1] == MAGIC_0
            && frame_bytes[3] == MAGIC_C;
        is_key = head && frame_bytes[2] == MAGIC_K;
        panel_frame = head && frame_bytes[2] == MAGIC_P;
        rx_crc = {frame_bytes[14], frame_bytes[15]};
        if ((!is_key && !panel_frame) || frame_bytes[4] != VERSION
            || frame_bytes[12] != 8'd0 || frame_bytes[13] != 8'd0)
            return VERDICT_HEADER;
        if (rx_crc != crc_run)
            return VERDICT_CRC;
        if (is_key)
        begin
            if (frame_bytes[5] == 8'd0 || frame_bytes[5] > cfg_max_key
                || (frame_bytes[6] != KEY_DOWN && frame_bytes[6] != KEY_UP)
                || frame_bytes[7] != 8'd0)
                return VERDICT_KEY_FIELDS;
            return VERDICT_KEY;
        end
        if (frame_bytes[5] == TGT_SWITCH && frame_bytes[7] <= 8'd1)
            return VERDICT_SWITCH;
        if (frame_bytes[5] == TGT_BUZZER && frame_bytes[6] == 8'd0 && frame_bytes[7] <= 8'd1)
            return VERDICT_BUZZER;
        if (frame_bytes[5] == TGT_MODE
            && (frame_bytes[6] == MODE_NORMAL || frame_bytes[6] == MODE_ALT)
            && frame_bytes[7] == 8'd0)
            return VERDICT_MODE;
        return VERDICT_PANEL;
    endfunction

    // fold one accepted byte into the tracker, queue a verdict on the last one
    task automatic absorb_byte(input byte_beat_t b);
        result_beat_t want;
        if (frame_len < FRAME_BYTES)
        begin
            frame_bytes[frame_len] = b.data_byte;
            if (frame_len < CRC_SPAN)
                crc_run = crc_step(crc_run, b.data_byte);
            frame_len++;
        end
        if (b.last_byte)
        begin
            want = '0;
            if (frame_len != FRAME_BYTES || b.source_ip != cfg_server_ip
                || b.source_port != cfg_server_port)
                want.verdict = VERDICT_LENGTH;
            else
            begin
                want.verdict = judge_frame();
                want.target = frame_bytes[5];
                want.action = frame_bytes[6];
                want.value = frame_bytes[7];
                want.cmd_word = {frame_bytes[8], frame_bytes[9],
                                 frame_bytes[10], frame_bytes[11]};
                want.frame_crc = {frame_bytes[14], frame_bytes[15]};
                want.computed_crc = crc_run;
            end
            expected_verdicts.push_back(want);
            frame_len = 0;
            crc_run = CRC_INIT;
        end
    endtask

    task automatic check_result(input result_beat_t got);
        result_beat_t want;
        if (got.verdict < 4'd9)
            verdict_tally[got.verdict]++;
        if (expected_verdicts.size() == 0)
        begin
            report_error($sformatf("verdict %0d with no frame pending", got.verdict));
            return;
        end
        want = expected_verdicts.pop_front();
        if (got.verdict !== want.verdict)
            report_error($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
        if (got.target !== want.target)
            report_error($sformatf("target %h, expected %h", got.target, want.target));
        if (got.action !== want.action)
            report_error($sformatf("action %h, expected %h", got.action, want.action));
        if (got.value !== want.value)
            report_error($sformatf("value %h, expected %h", got.value, want.value));
        if (got.cmd_word !== want.cmd_word)
            report_error($sformatf("cmd_word %h, expected %h",
                                   got.cmd_word, want.cmd_word));
        if (got.frame_crc !== want.frame_crc)
            report_error($sformatf("frame_crc %h, expected %h",
                                   got.frame_crc, want.frame_crc));
        if (got.computed_crc !== want.computed_crc)
            report_error($sformatf("computed_crc %h, expected %h",
                                   got.computed_crc, want.computed_crc));
    endtask

    // byte driver: one beat in flight, refilled from the backlog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            frame_len = 0;
            crc_run = CRC_INIT;
            bytes_taken = 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                absorb_byte(byte_data);
                bytes_taken++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_data <= byte_backlog.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // result monitor and random stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_result(result_data);
            result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // long hold-off on the result side, counted here
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // apb write: setup cycle, then access until pready
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_registers(input logic [31:0] ip, input logic [15:0] port,
                                     input logic [7:0] key_limit);
        reg_write(REG_SERVER_IP, ip);
        reg_write(REG_SERVER_PORT, {16'd0, port});
        reg_write(REG_MAX_KEY, {24'd0, key_limit});
        @(negedge clk);
        cfg_server_ip = ip;
        cfg_server_port = port;
        cfg_max_key = key_limit;
    endtask

    // wait until every queued byte is taken and every verdict has come back
    task automatic drain();
        do
            @(negedge clk);
        while (byte_backlog.size() != 0 || byte_valid || expected_verdicts.size() != 0);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic seal_draft();
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++)
            c = crc_step(c, draft[i]);
        draft[14] = c[15:8];
        draft[15] = c[7:0];
    endtask

    task automatic compose(input logic [7:0] kind, input logic [7:0] tgt,
                           input logic [7:0] act, input logic [7:0] val,
                           input logic [31:0] cmd);
        draft[0] = MAGIC_M;
        draft[1] = MAGIC_0;
        draft[2] = kind;
        draft[3] = MAGIC_C;
        draft[4] = VERSION;
        draft[5] = tgt;
        draft[6] = act;
        draft[7] = val;
        {draft[8], draft[9], draft[10], draft[11]} = cmd;
        draft[12] = 8'd0;
        draft[13] = 8'd0;
        seal_draft();
    endtask

    // queue len bytes of the draft; bytes past the frame size are random filler
    task automatic send_draft(input int len, input logic [31:0] ip, input logic [15:0] port);
        byte_beat_t b;
        for (int i = 0; i < len; i++)
        begin
            b.data_byte = (i < FRAME_BYTES) ? draft[i] : 8'($urandom);
            b.last_byte = (i == len - 1);
            b.source_ip = b.last_byte ? ip : $urandom;
            b.source_port = b.last_byte ? port : 16'($urandom);
            byte_backlog.push_back(b);
            if (i < FRAME_BYTES)
                bytes_queued++;
        end
    endtask

    function automatic logic [7:0] pick_key();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd1;
            2: return cfg_max_key;
            3: return cfg_max_key + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        int          pick;
        int          len;
        int          spot;
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  tgt;
        logic [7:0]  act;
        logic [7:0]  val;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            if (pick < 35)
            begin
                tgt = pick_key();
                act = ($urandom_range(9) < 7) ? (($urandom_range(1) != 0) ? KEY_UP : KEY_DOWN)
                                              : 8'($urandom);
                val = ($urandom_range(9) < 8) ? 8'd0 : 8'($urandom);
                compose(MAGIC_K, tgt, act, val, $urandom);
            end
            else
            begin
                tgt = ($urandom_range(9) < 8) ? 8'($urandom_range(4)) : 8'($urandom);
                case ($urandom_range(3))
                    0: act = MODE_NORMAL;
                    1: act = MODE_ALT;
                    2: act = 8'd1;
                    default: act = 8'($urandom);
                endcase
                case ($urandom_range(2))
                    0: val = 8'd0;
                    1: val = 8'd1;
                    default: val = 8'($urandom);
                endcase
                compose(MAGIC_P, tgt, act, val, $urandom);
            end
        end
        else if (pick < 90)
        begin
            // well-formed frame with one defect
            compose(($urandom_range(1) != 0) ? MAGIC_K : MAGIC_P, 8'd1, KEY_DOWN, 8'd0,
                    $urandom);
            case ($urandom_range(3))
                0:
                begin
                    spot = $urandom_range(3);
                    draft[spot] = 8'($urandom);
                    seal_draft();
                end
                1:
                begin
                    draft[4] = 8'($urandom);
                    seal_draft();
                end
                2:
                begin
                    draft[12 + $urandom_range(1)] = 8'($urandom_range(1, 255));
                    seal_draft();
                end
                default:
                begin
                    spot = $urandom_range(FRAME_BYTES - 1);
                    draft[spot] = draft[spot] ^ (8'd1 << $urandom_range(7));
                end
            endcase
        end
        else
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
                draft[i] = 8'($urandom);
        end

        ip = cfg_server_ip;
        port = cfg_server_port;
        case ($urandom_range(19))
            0: ip = ip ^ (32'd1 << $urandom_range(31));
            1: port = port ^ (16'd1 << $urandom_range(15));
            2: ip = $urandom;
            default: ;
        endcase
        case ($urandom_range(19))
            0: len = $urandom_range(1, FRAME_BYTES - 1);
            1: len = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8);
            default: len = FRAME_BYTES;
        endcase
        if (pick >= 90 && $urandom_range(1) != 0)
            len = $urandom_range(1, FRAME_BYTES + 4);
        send_draft(len, ip, port);
    endtask

    task automatic random_traffic(input int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target)
            send_random_frame();
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
    endtask

    // stimulus sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames on reset defaults
        set_idling(15, 64);
        compose(MAGIC_K, 8'd1, KEY_DOWN, 8'd0, 32'h0000_0000);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_K, MAX_KEY_RESET, KEY_UP, 8'd0, 32'hFFFF_FFFF);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_K, 8'd0, KEY_DOWN, 8'd0, 32'h1234_5678);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_K, MAX_KEY_RESET + 8'd1, KEY_UP, 8'd1, 32'h8000_0001);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_P, TGT_SWITCH, 8'hFF, 8'd1, 32'hA5A5_5A5A);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_P, TGT_BUZZER, 8'd0, 8'd0, 32'h0000_0042);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_P, TGT_MODE, MODE_ALT, 8'd0, 32'h0BAD_F00D);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_P, TGT_MODE, 8'd5, 8'd0, 32'h0000_0003);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        // header defects: version, reserved byte, unknown magic
        compose(MAGIC_K, 8'd2, KEY_DOWN, 8'd0, 32'h0000_0010);
        draft[4] = 8'd2;
        seal_draft();
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(MAGIC_P, TGT_SWITCH, 8'd0, 8'd0, 32'h0000_0011);
        draft[13] = 8'hFF;
        seal_draft();
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        compose(8'h58, TGT_SWITCH, 8'd0, 8'd0, 32'h0000_0012);
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        // corrupted crc
        compose(MAGIC_K, 8'd3, KEY_DOWN, 8'd0, 32'h0000_0013);
        draft[15] = draft[15] ^ 8'h80;
        send_draft(FRAME_BYTES, 32'd0, 16'd0);
        // single byte, short frame, long frame
        draft[0] = 8'hFF;
        send_draft(1, 32'd0, 16'd0);
        compose(MAGIC_K, 8'd4, KEY_DOWN, 8'd0, 32'h0000_0014);
        send_draft(FRAME_BYTES - 1, 32'd0, 16'd0);
        compose(MAGIC_K, 8'd5, KEY_UP, 8'd0, 32'h0000_0015);
        send_draft(FRAME_BYTES + 4, 32'd0, 16'd0);
        // wrong sender address, wrong sender port
        send_draft(FRAME_BYTES, 32'd1, 16'd0);
        send_draft(FRAME_BYTES, 32'd0, 16'h8000);
        drain();

        // top of every register range, with a long result hold-off
        program_registers(32'hFFFF_FFFF, 16'hFFFF, 8'd255);
        hold_requests = hold_requests + 1;
        random_traffic(300);
        drain();

        // smallest key limit
        set_idling(64, 15);
        program_registers($urandom, 16'($urandom), 8'd1);
        random_traffic(300);
        drain();

        program_registers($urandom, 16'($urandom), 8'($urandom_range(2, 254)));
        random_traffic(300);
        drain();

        // no idling at all
        set_idling(0, 0);
        program_registers(32'd0, 16'($urandom), 8'($urandom_range(1, 255)));
        random_traffic(300);
        drain();

        if (expected_verdicts.size() != 0)
            report_error($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        $display("checked %0d bytes and %0d verdicts over five register settings",
                 bytes_taken, verdict_tally.sum());
        $display("commands key/switch/buzzer/mode %0d/%0d/%0d/%0d, rejects %0d",
                 verdict_tally[VERDICT_KEY], verdict_tally[VERDICT_SWITCH],
                 verdict_tally[VERDICT_BUZZER], verdict_tally[VERDICT_MODE],
                 verdict_tally.sum() - verdict_tally[VERDICT_KEY]
                 - verdict_tally[VERDICT_SWITCH] - verdict_tally[VERDICT_BUZZER]
                 - verdict_tally[VERDICT_MODE]);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 9; i++)
            verdict_tally[i] = 0;
    end

endmodule
